/* design/atok_pkg.sv */
// shared types and constants for the arithmetic expression tokenizer
// holds token kinds, character codes, the result beat struct and saturating helpers
// no dependencies
package atok_pkg;

    localparam int INDEX_BITS = 24;
    localparam int POS_BITS   = 16;
    localparam int KIND_BITS  = 4;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
    localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INT     = 4'd0,
        KIND_FLOAT   = 4'd1,
        KIND_ADD     = 4'd2,
        KIND_SUB     = 4'd3,
        KIND_MUL     = 4'd4,
        KIND_DIV     = 4'd5,
        KIND_LPAR    = 4'd6,
        KIND_RPAR    = 4'd7,
        KIND_ILLEGAL = 4'd8,
        KIND_XDOT    = 4'd9
    } token_kind_t;

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LPAR    = 8'h28;
    localparam logic [7:0] CH_RPAR    = 8'h29;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef struct packed {
        token_kind_t           kind;
        logic [INDEX_BITS-1:0] start_index;
        logic [POS_BITS-1:0]   length;
        logic [POS_BITS-1:0]   line;
        logic [POS_BITS-1:0]   column;
        logic [7:0]            bad_char;
        logic                  last;
    } tok_result_t;

    function automatic logic [INDEX_BITS-1:0] sat_inc_index(input logic [INDEX_BITS-1:0] v);
        logic [INDEX_BITS-1:0] r;
        r = (v == INDEX_MAX) ? v : v + 1'b1;
        return r;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc_pos(input logic [POS_BITS-1:0] v);
        logic [POS_BITS-1:0] r;
        r = (v == POS_MAX) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

/* design/atok_lexer.sv */
// lexer state and per-byte classification for the arithmetic expression tokenizer
// turns one accepted byte into zero, one or two result beats and updates position state
// depends on atok_pkg
module atok_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          ch,
    input  logic                end_of_text,
    output atok_pkg::tok_result_t res0,
    output atok_pkg::tok_result_t res1,
    output logic [1:0]          res_count
);
    import atok_pkg::*;

    logic                  in_number_reg, in_number_next;
    logic                  dot_seen_reg, dot_seen_next;
    logic [INDEX_BITS-1:0] num_index_reg, num_index_next;
    logic [POS_BITS-1:0]   num_line_reg, num_line_next;
    logic [POS_BITS-1:0]   num_col_reg, num_col_next;
    logic [POS_BITS-1:0]   num_length_reg, num_length_next;
    logic [INDEX_BITS-1:0] char_index_reg, char_index_next;
    logic [POS_BITS-1:0]   char_line_reg, char_line_next;
    logic [POS_BITS-1:0]   char_col_reg, char_col_next;

    logic        numeric;
    logic        is_dot;
    logic        skip;
    token_kind_t op_kind;
    tok_result_t first_res, second_res, num_cur, num_upd, char_res;
    logic        first_ok, second_ok;

    always_comb
    begin
        is_dot  = (ch == CH_DOT);
        numeric = ((ch >= CH_ZERO) && (ch <= CH_NINE)) || is_dot;

        skip    = 1'b0;
        op_kind = KIND_ILLEGAL;
        case (ch)
            CH_SPACE, CH_TAB: skip = 1'b1;
            CH_PLUS:  op_kind = KIND_ADD;
            CH_MINUS: op_kind = KIND_SUB;
            CH_STAR:  op_kind = KIND_MUL;
            CH_SLASH: op_kind = KIND_DIV;
            CH_LPAR:  op_kind = KIND_LPAR;
            CH_RPAR:  op_kind = KIND_RPAR;
            default:  op_kind = KIND_ILLEGAL;
        endcase

        // number state as it stands after this byte, if numeric
        if (in_number_reg)
        begin
            dot_seen_next   = dot_seen_reg | is_dot;
            num_index_next  = num_index_reg;
            num_line_next   = num_line_reg;
            num_col_next    = num_col_reg;
            num_length_next = sat_inc_pos(num_length_reg);
        end
        else
        begin
            dot_seen_next   = is_dot;
            num_index_next  = char_index_reg;
            num_line_next   = char_line_reg;
            num_col_next    = char_col_reg;
            num_length_next = {{(POS_BITS-1){1'b0}}, 1'b1};
        end

        num_cur.kind        = dot_seen_reg ? KIND_FLOAT : KIND_INT;
        num_cur.start_index = num_index_reg;
        num_cur.length      = num_length_reg;
        num_cur.line        = num_line_reg;
        num_cur.column      = num_col_reg;
        num_cur.bad_char    = 8'h00;
        num_cur.last        = 1'b0;

        num_upd.kind        = dot_seen_next ? KIND_FLOAT : KIND_INT;
        num_upd.start_index = num_index_next;
        num_upd.length      = num_length_next;
        num_upd.line        = num_line_next;
        num_upd.column      = num_col_next;
        num_upd.bad_char    = 8'h00;
        num_upd.last        = 1'b0;

        // single-byte beat at the current position: operator or error
        char_res.kind        = numeric ? KIND_XDOT : op_kind;
        char_res.start_index = char_index_reg;
        char_res.length      = {{(POS_BITS-1){1'b0}}, 1'b1};
        char_res.line        = char_line_reg;
        char_res.column      = char_col_reg;
        char_res.bad_char    = (!numeric && op_kind == KIND_ILLEGAL) ? ch : 8'h00;
        char_res.last        = 1'b0;

        if (numeric)
        begin
            first_res  = char_res;
            first_ok   = in_number_reg & dot_seen_reg & is_dot;
            second_res = num_upd;
            second_ok  = end_of_text;
        end
        else
        begin
            first_res  = num_cur;
            first_ok   = in_number_reg;
            second_res = char_res;
            second_ok  = !skip;
        end

        res0 = first_ok ? first_res : second_res;
        res1 = second_res;
        res0.last = !(first_ok && second_ok);
        res1.last = 1'b1;
        res_count = {1'b0, first_ok} + {1'b0, second_ok};

        // state update
        char_index_next = sat_inc_index(char_index_reg);
        if (ch == CH_NEWLINE)
        begin
            char_line_next = sat_inc_pos(char_line_reg);
            char_col_next  = '0;
        end
        else
        begin
            char_line_next = char_line_reg;
            char_col_next  = sat_inc_pos(char_col_reg);
        end

        in_number_next = numeric;
        if (!numeric)
        begin
            dot_seen_next   = 1'b0;
            num_length_next = '0;
            num_index_next  = num_index_reg;
            num_line_next   = num_line_reg;
            num_col_next    = num_col_reg;
        end

        // final byte: everything back to the start of a fresh text
        if (end_of_text)
        begin
            in_number_next  = 1'b0;
            dot_seen_next   = 1'b0;
            num_index_next  = '0;
            num_line_next   = {{(POS_BITS-1){1'b0}}, 1'b1};
            num_col_next    = '0;
            num_length_next = '0;
            char_index_next = '0;
            char_line_next  = {{(POS_BITS-1){1'b0}}, 1'b1};
            char_col_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_number_reg  <= 1'b0;
            dot_seen_reg   <= 1'b0;
            num_index_reg  <= '0;
            num_line_reg   <= {{(POS_BITS-1){1'b0}}, 1'b1};
            num_col_reg    <= '0;
            num_length_reg <= '0;
            char_index_reg <= '0;
            char_line_reg  <= {{(POS_BITS-1){1'b0}}, 1'b1};
            char_col_reg   <= '0;
        end
        else if (accept)
        begin
            in_number_reg  <= in_number_next;
            dot_seen_reg   <= dot_seen_next;
            num_index_reg  <= num_index_next;
            num_line_reg   <= num_line_next;
            num_col_reg    <= num_col_next;
            num_length_reg <= num_length_next;
            char_index_reg <= char_index_next;
            char_line_reg  <= char_line_next;
            char_col_reg   <= char_col_next;
        end
    end

endmodule

/* design/atok_queue.sv */
// four-entry result queue for the arithmetic expression tokenizer
// takes up to two result beats per cycle and hands out one per cycle on pop
// depends on atok_pkg
module atok_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  atok_pkg::tok_result_t push0,
    input  atok_pkg::tok_result_t push1,
    input  logic [1:0]          push_count,
    input  logic                pop,
    output atok_pkg::tok_result_t head,
    output logic                head_valid,
    output logic                has_room
);
    import atok_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    tok_result_t           entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]     count_reg, count_next;
    logic [PTR_BITS-1:0]   wr_ptr_plus1;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    // room for a worst-case pair of beats
    assign has_room   = (count_reg <= (PTR_BITS+1)'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + (PTR_BITS+1)'(push_count) - (PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

endmodule

/* design/arith_expression_tokenizer_core.sv */
// Arithmetic expression tokenizer, one text byte per input beat.
// Input channel: in_valid/in_ready with ch and end_of_text; end_of_text marks
// the final byte of a text, after which positions restart at index 0, line 1,
// column 0. Output channel: out_valid/out_ready with one token or error per
// beat; last is set on the final beat caused by an input byte.
// Spaces and tabs give no beat; a number is reported by start and length once
// a non-number byte or the final byte arrives; an extra dot gives an error beat
// and the number goes on; any other unknown byte gives an illegal-char beat.
// With the queue empty, a byte's first beat is visible in the cycle after it
// is accepted; beats already waiting go out first.
// Throughput: one byte per cycle while the receiver keeps up; a byte can give
// two beats and the output port moves one per cycle, so bytes that close a
// number with an operator are limited by the output rate.
// A four-entry result queue sits between the lexer and the output port; in_ready
// is high while it holds two beats or fewer, so under a stalled receiver input
// stops once more than two beats wait; blank bytes give no beat but wait too.
// Reset clears all lexer state and empties the queue; no clearing pass.
// Depends on atok_pkg, atok_lexer, atok_queue.
module arith_expression_tokenizer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     ch,
    input  logic                           end_of_text,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [atok_pkg::KIND_BITS-1:0] token_kind,
    output logic [atok_pkg::INDEX_BITS-1:0] start_index,
    output logic [atok_pkg::POS_BITS-1:0]  token_length,
    output logic [atok_pkg::POS_BITS-1:0]  start_line,
    output logic [atok_pkg::POS_BITS-1:0]  start_column,
    output logic [7:0]                     bad_char,
    output logic                           last
);
    import atok_pkg::*;

    logic        accept;
    logic        has_room;
    tok_result_t res0, res1, head;
    logic [1:0]  res_count;
    logic [1:0]  push_count;

    assign in_ready   = has_room;
    assign accept     = in_valid & has_room;
    assign push_count = accept ? res_count : 2'd0;

    atok_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ch          (ch),
        .end_of_text (end_of_text),
        .res0        (res0),
        .res1        (res1),
        .res_count   (res_count)
    );

    atok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (res0),
        .push1      (res1),
        .push_count (push_count),
        .pop        (out_valid & out_ready),
        .head       (head),
        .head_valid (out_valid),
        .has_room   (has_room)
    );

    assign token_kind   = head.kind;
    assign start_index  = head.start_index;
    assign token_length = head.length;
    assign start_line   = head.line;
    assign start_column = head.column;
    assign bad_char     = head.bad_char;
    assign last         = head.last;

endmodule

/* dv/tb.sv */
// testbench for arith_expression_tokenizer_core: table-driven directed bytes,
// then random expression texts under input idling and output stalls
// depends on atok_pkg and the tokenizer RTL
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atok_pkg::*;

    localparam tok_result_t NO_TOK = '0;

    typedef struct packed {
        logic [7:0]  b;
        logic        fin;
        logic [1:0]  n_typed;
        tok_result_t want0;
        tok_result_t want1;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            ch = 8'h00;
    logic                  end_of_text = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [KIND_BITS-1:0]  token_kind;
    logic [INDEX_BITS-1:0] start_index;
    logic [POS_BITS-1:0]   token_length;
    logic [POS_BITS-1:0]   start_line;
    logic [POS_BITS-1:0]   start_column;
    logic [7:0]            bad_char;
    logic                  last;

    arith_expression_tokenizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_index  (start_index),
        .token_length (token_length),
        .start_line   (start_line),
        .start_column (start_column),
        .bad_char     (bad_char),
        .last         (last)
    );

    // lexer mirror state
    logic                  pend_active;
    logic                  pend_dotted;
    logic [INDEX_BITS-1:0] pend_index;
    logic [POS_BITS-1:0]   pend_line;
    logic [POS_BITS-1:0]   pend_column;
    logic [POS_BITS-1:0]   pend_length;
    logic [INDEX_BITS-1:0] pos_index;
    logic [POS_BITS-1:0]   pos_line;
    logic [POS_BITS-1:0]   pos_column;

    tok_result_t lexed[$];
    tok_result_t tokens_due[$];
    tok_result_t due_tok;
    stim_row_t   directed_rows[$];

    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int bytes_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_error(input string msg);
        // cap the printout, keep counting
        if (error_count < 40)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h expected 0x%0h (expected kind %0d index %0d)",
                                   name, got, want, due_tok.kind, due_tok.start_index));
    endtask

    function automatic tok_result_t tok(input token_kind_t k,
                                        input logic [INDEX_BITS-1:0] idx,
                                        input logic [POS_BITS-1:0] len,
                                        input logic [POS_BITS-1:0] line,
                                        input logic [POS_BITS-1:0] col,
                                        input logic [7:0] bad, input logic lst);
        tok_result_t r;
        r.kind        = k;
        r.start_index = idx;
        r.length      = len;
        r.line        = line;
        r.column      = col;
        r.bad_char    = bad;
        r.last        = lst;
        return r;
    endfunction

    function automatic stim_row_t row(input logic [7:0] b, input logic fin,
                                      input logic [1:0] n,
                                      input tok_result_t w0, input tok_result_t w1);
        stim_row_t r;
        r.b       = b;
        r.fin     = fin;
        r.n_typed = n;
        r.want0   = w0;
        r.want1   = w1;
        return r;
    endfunction

    function automatic logic [POS_BITS-1:0] bump_pos(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    task automatic clear_lexer();
        pend_active = 1'b0;
        pend_dotted = 1'b0;
        pend_index  = '0;
        pend_line   = POS_BITS'(1);
        pend_column = '0;
        pend_length = '0;
        pos_index   = '0;
        pos_line    = POS_BITS'(1);
        pos_column  = '0;
    endtask

    task automatic flush_number();
        if (pend_active)
        begin
            lexed.push_back(tok(pend_dotted ? KIND_FLOAT : KIND_INT, pend_index, pend_length,
                                pend_line, pend_column, 8'h00, 1'b0));
            pend_active = 1'b0;
            pend_dotted = 1'b0;
            pend_length = '0;
        end
    endtask

    // works out the beats one byte causes and advances the mirror state
    task automatic lex_byte(input logic [7:0] b, input logic fin);
        token_kind_t k;
        logic        skip;
        logic        numeric;
        lexed.delete();
        skip = 1'b0;
        k = KIND_ILLEGAL;
        numeric = (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT;
        if (numeric)
        begin
            if (!pend_active)
            begin
                pend_active = 1'b1;
                pend_dotted = (b == CH_DOT);
                pend_index  = pos_index;
                pend_line   = pos_line;
                pend_column = pos_column;
                pend_length = POS_BITS'(1);
            end
            else
            begin
                if (b == CH_DOT)
                begin
                    if (pend_dotted)
                        lexed.push_back(tok(KIND_XDOT, pos_index, POS_BITS'(1), pos_line,
                                            pos_column, 8'h00, 1'b0));
                    pend_dotted = 1'b1;
                end
                pend_length = bump_pos(pend_length);
            end
        end
        else
        begin
            flush_number();
            case (b)
                CH_SPACE, CH_TAB: skip = 1'b1;
                CH_PLUS:          k = KIND_ADD;
                CH_MINUS:         k = KIND_SUB;
                CH_STAR:          k = KIND_MUL;
                CH_SLASH:         k = KIND_DIV;
                CH_LPAR:          k = KIND_LPAR;
                CH_RPAR:          k = KIND_RPAR;
                default:          k = KIND_ILLEGAL;
            endcase
            if (!skip)
                lexed.push_back(tok(k, pos_index, POS_BITS'(1), pos_line, pos_column,
                                    (k == KIND_ILLEGAL) ? b : 8'h00, 1'b0));
        end
        if (fin)
            flush_number();
        pos_index = (pos_index == INDEX_MAX) ? pos_index : pos_index + 1'b1;
        if (b == CH_NEWLINE)
        begin
            pos_line   = bump_pos(pos_line);
            pos_column = '0;
        end
        else
        begin
            pos_column = bump_pos(pos_column);
        end
        if (fin)
            clear_lexer();
        if (lexed.size() > 0)
            lexed[lexed.size()-1].last = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic [1:0] n_typed,
                             input tok_result_t w0, input tok_result_t w1);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        ch          <= b;
        end_of_text <= fin;
        do @(posedge clk); while (!in_ready);
        lex_byte(b, fin);
        if (n_typed == 0)
        begin
            foreach (lexed[i])
                tokens_due.push_back(lexed[i]);
        end
        else
        begin
            tokens_due.push_back(w0);
            if (n_typed == 2)
                tokens_due.push_back(w1);
        end
        bytes_sent++;
    endtask

    // one text of expression-like tokens with some noise, final byte flagged
    task automatic gen_text();
        logic [7:0] text_q[$];
        int         pick;
        int         digits;
        int         first;
        repeat ($urandom_range(1, 10))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                digits = $urandom_range(1, 6);
                first = text_q.size();
                repeat (digits) text_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                if ($urandom_range(0, 99) < 35)
                    text_q.insert(first + $urandom_range(0, digits), CH_DOT);
                if ($urandom_range(0, 99) < 8)
                    text_q.insert(first + $urandom_range(0, digits), CH_DOT);
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 5))
                    0:       text_q.push_back(CH_PLUS);
                    1:       text_q.push_back(CH_MINUS);
                    2:       text_q.push_back(CH_STAR);
                    3:       text_q.push_back(CH_SLASH);
                    4:       text_q.push_back(CH_LPAR);
                    default: text_q.push_back(CH_RPAR);
                endcase
            end
            else if (pick < 90)
                text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            else if (pick < 95)
                text_q.push_back(CH_NEWLINE);
            else
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1, 0, NO_TOK, NO_TOK);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tokens_due.size() == 0)
                report_error($sformatf("beat with nothing expected: kind %0d index %0d",
                                       token_kind, start_index));
            else
            begin
                due_tok = tokens_due.pop_front();
                check_field("token_kind", token_kind, due_tok.kind);
                check_field("start_index", start_index, due_tok.start_index);
                check_field("token_length", token_length, due_tok.length);
                check_field("start_line", start_line, due_tok.line);
                check_field("start_column", start_column, due_tok.column);
                check_field("bad_char", bad_char, due_tok.bad_char);
                check_field("last", last, due_tok.last);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        int drain;
        clear_lexer();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // float with an extra dot, every operator, blanks, illegal bytes
        directed_rows.push_back(row(CH_LPAR, 0, 1, tok(KIND_LPAR, 0, 1, 1, 0, 0, 1), NO_TOK));
        directed_rows.push_back(row("9", 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row(CH_DOT, 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row(CH_DOT, 0, 1, tok(KIND_XDOT, 3, 1, 1, 3, 0, 1), NO_TOK));
        directed_rows.push_back(row("0", 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row(CH_PLUS, 0, 2, tok(KIND_FLOAT, 1, 4, 1, 1, 0, 0),
                                    tok(KIND_ADD, 5, 1, 1, 5, 0, 1)));
        directed_rows.push_back(row(CH_SPACE, 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row(CH_TAB, 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row(CH_MINUS, 0, 1, tok(KIND_SUB, 8, 1, 1, 8, 0, 1), NO_TOK));
        directed_rows.push_back(row(CH_STAR, 0, 1, tok(KIND_MUL, 9, 1, 1, 9, 0, 1), NO_TOK));
        directed_rows.push_back(row(CH_SLASH, 0, 1, tok(KIND_DIV, 10, 1, 1, 10, 0, 1), NO_TOK));
        directed_rows.push_back(row(CH_RPAR, 0, 1, tok(KIND_RPAR, 11, 1, 1, 11, 0, 1), NO_TOK));
        directed_rows.push_back(row(CH_NEWLINE, 0, 1,
                                    tok(KIND_ILLEGAL, 12, 1, 1, 12, CH_NEWLINE, 1), NO_TOK));
        directed_rows.push_back(row(8'hFF, 0, 1, tok(KIND_ILLEGAL, 13, 1, 2, 0, 8'hFF, 1),
                                    NO_TOK));
        directed_rows.push_back(row(8'h00, 0, 1, tok(KIND_ILLEGAL, 14, 1, 2, 1, 8'h00, 1),
                                    NO_TOK));
        directed_rows.push_back(row("7", 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row("3", 1, 1, tok(KIND_INT, 15, 2, 2, 2, 0, 1), NO_TOK));
        // single-byte texts and numbers closed by the final byte
        directed_rows.push_back(row("5", 1, 1, tok(KIND_INT, 0, 1, 1, 0, 0, 1), NO_TOK));
        directed_rows.push_back(row(CH_DOT, 1, 1, tok(KIND_FLOAT, 0, 1, 1, 0, 0, 1), NO_TOK));
        directed_rows.push_back(row("8", 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row(CH_STAR, 1, 2, tok(KIND_INT, 0, 1, 1, 0, 0, 0),
                                    tok(KIND_MUL, 1, 1, 1, 1, 0, 1)));
        directed_rows.push_back(row(CH_DOT, 0, 0, NO_TOK, NO_TOK));
        // extra dot on the final byte comes before the number it belongs to
        directed_rows.push_back(row(CH_DOT, 1, 2, tok(KIND_XDOT, 1, 1, 1, 1, 0, 0),
                                    tok(KIND_FLOAT, 0, 2, 1, 0, 0, 1)));
        directed_rows.push_back(row(CH_SPACE, 1, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row("4", 0, 0, NO_TOK, NO_TOK));
        directed_rows.push_back(row(CH_TAB, 1, 1, tok(KIND_INT, 0, 1, 1, 0, 0, 1), NO_TOK));
        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].n_typed,
                      directed_rows[i].want0, directed_rows[i].want1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 53; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            bytes_sent = 0;
            while (bytes_sent < 420)
                gen_text();
        end
        in_valid <= 1'b0;

        drain = 0;
        while (tokens_due.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (tokens_due.size() != 0)
            report_error($sformatf("%0d expected beats never arrived", tokens_due.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
